FILE: hw/rtl/pseb_pkg.sv
// Package for the plane slice edge bounds block: widths, word types,
// controller state codes and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package pseb_pkg;

  localparam int COORD_W   = 32;
  localparam int NUM_W     = 2 * COORD_W + 1;   // x1*z2 - z1*x2, exact
  localparam int DEN_W     = COORD_W + 1;       // z2 - z1 and its magnitude
  localparam int CNT_W     = $clog2(COORD_W);
  localparam int MUL_STEPS = 4;
  localparam int MUL_SEL_W = $clog2(MUL_STEPS);

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // multiplier pass order
  localparam logic [MUL_SEL_W-1:0] MUL_XA = 2'd0;  // x1*z2
  localparam logic [MUL_SEL_W-1:0] MUL_XB = 2'd1;  // z1*x2
  localparam logic [MUL_SEL_W-1:0] MUL_YA = 2'd2;  // y1*z2
  localparam logic [MUL_SEL_W-1:0] MUL_YB = 2'd3;  // z1*y2

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_PREP = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_UPD  = 5'b10000
  } state_t;

  typedef struct packed {
    logic                 load;
    logic                 mul_en;
    logic [MUL_SEL_W-1:0] mul_step;
    logic                 prep;
    logic                 div_en;
    logic                 upd;
  } cmd_t;

  typedef struct packed {
    logic crossing;
    logic last;
    logic out_busy;
  } sts_t;

endpackage

FILE: hw/rtl/pseb_if.sv
// Handshake channels of the plane slice edge bounds block: edge words in,
// rectangle words out. Depends on pseb_pkg.
`timescale 1ns / 1ps

interface pseb_in_if import pseb_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t start_z;
  coord_t end_x;
  coord_t end_y;
  coord_t end_z;
  logic   last_edge;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  last_edge, input ready);
  modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  last_edge, output ready);
endinterface

interface pseb_out_if import pseb_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t low_x;
  coord_t high_x;
  coord_t low_y;
  coord_t high_y;
  logic   found;

  modport source (output valid, low_x, high_x, low_y, high_y, found, input ready);
  modport sink   (input valid, low_x, high_x, low_y, high_y, found, output ready);
endinterface

FILE: hw/rtl/pseb_ctrl.sv
// Controller of the plane slice edge bounds block: one-hot sequencer for
// multiply passes, divider steps and the bounds update. Depends on pseb_pkg.
`timescale 1ns / 1ps

module pseb_ctrl import pseb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.load     = in_valid && in_ready;
    cmd.mul_step = cnt_r[MUL_SEL_W-1:0];
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MUL;
          cnt_nxt   = '0;
        end
      end
      ST_MUL: begin
        if (!sts.crossing) begin
          state_nxt = ST_UPD;     // no crossing: nothing to compute
        end else begin
          cmd.mul_en = 1'b1;
          if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
            state_nxt = ST_PREP;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
        if (cnt_r == CNT_W'(COORD_W - 1)) begin
          state_nxt = ST_UPD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_UPD: begin
        // a final edge waits until the result register is free
        if (!(sts.last && sts.out_busy)) begin
          cmd.upd   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: hw/rtl/pseb_datapath.sv
// Datapath of the plane slice edge bounds block: edge registers, shared
// multiplier, two radix-2 dividers, running bounds and result register.
// Depends on pseb_pkg.
`timescale 1ns / 1ps

module pseb_datapath import pseb_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cmd_t   cmd,
  output sts_t   sts,
  input  coord_t in_start_x,
  input  coord_t in_start_y,
  input  coord_t in_start_z,
  input  coord_t in_end_x,
  input  coord_t in_end_y,
  input  coord_t in_end_z,
  input  logic   in_last_edge,
  output logic   out_valid,
  input  logic   out_ready,
  output coord_t out_low_x,
  output coord_t out_high_x,
  output coord_t out_low_y,
  output coord_t out_high_y,
  output logic   out_found
);

  // restoring step: {rem, q} -> {rem', q'}, quotient bit shifts in at q[0]
  function automatic logic [DEN_W+COORD_W-1:0] div_step(
    input logic [DEN_W-1:0]   rem,
    input logic [COORD_W-1:0] q,
    input logic [DEN_W-1:0]   d
  );
    logic [DEN_W:0]   sh;
    logic [DEN_W:0]   diff;
    logic             take;
    logic [DEN_W-1:0] rem_n;
    sh    = {rem, q[COORD_W-1]};
    diff  = sh - {1'b0, d};
    take  = (sh >= {1'b0, d});
    rem_n = take ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
    return {rem_n, q[COORD_W-2:0], take};
  endfunction

  // sign and saturation of a quotient magnitude
  function automatic coord_t finish(input logic [COORD_W-1:0] q, input logic neg);
    coord_t r;
    if (!neg) begin
      r = q[COORD_W-1] ? COORD_MAX : coord_t'(q);
    end else if (q[COORD_W-1] && (|q[COORD_W-2:0])) begin
      r = COORD_MIN;
    end else begin
      r = coord_t'(~q + 1'b1);
    end
    return r;
  endfunction

  coord_t x1_r, y1_r, z1_r, x2_r, y2_r, z2_r;
  logic   last_r;

  logic signed [NUM_W-1:0] num_x_r, num_y_r;
  logic [DEN_W-1:0]        d_r;
  logic [DEN_W-1:0]        rem_x_r, rem_y_r;
  logic [COORD_W-1:0]      q_x_r, q_y_r;
  logic                    neg_x_r, neg_y_r;

  coord_t run_low_x_r, run_high_x_r, run_low_y_r, run_high_y_r;
  logic   hit_r;

  logic   out_valid_r;
  coord_t out_low_x_r, out_high_x_r, out_low_y_r, out_high_y_r;
  logic   out_found_r;

  // edge classification
  logic crossing;
  assign crossing = (((z1_r <= 0) && (z2_r >= 0)) || ((z1_r >= 0) && (z2_r <= 0)))
                    && (z1_r != z2_r);

  assign sts.crossing = crossing;
  assign sts.last     = last_r;
  assign sts.out_busy = out_valid_r;

  // shared multiplier
  coord_t                    mul_a, mul_b;
  logic signed [2*COORD_W-1:0] prod;
  logic signed [NUM_W-1:0]   prod_ext;

  always_comb begin
    case (cmd.mul_step)
      MUL_XA:  begin mul_a = x1_r; mul_b = z2_r; end
      MUL_XB:  begin mul_a = z1_r; mul_b = x2_r; end
      MUL_YA:  begin mul_a = y1_r; mul_b = z2_r; end
      MUL_YB:  begin mul_a = z1_r; mul_b = y2_r; end
      default: begin mul_a = x1_r; mul_b = z2_r; end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_ext = {prod[2*COORD_W-1], prod};

  // divider setup
  logic signed [DEN_W-1:0] den;
  logic [DEN_W-1:0]        den_mag;
  logic [NUM_W-1:0]        nmag_x, nmag_y;

  assign den     = {z2_r[COORD_W-1], z2_r} - {z1_r[COORD_W-1], z1_r};
  assign den_mag = den[DEN_W-1] ? (~den + 1'b1) : den;
  assign nmag_x  = num_x_r[NUM_W-1] ? (~num_x_r + 1'b1) : num_x_r;
  assign nmag_y  = num_y_r[NUM_W-1] ? (~num_y_r + 1'b1) : num_y_r;

  logic [DEN_W+COORD_W-1:0] step_x, step_y;
  assign step_x = div_step(rem_x_r, q_x_r, d_r);
  assign step_y = div_step(rem_y_r, q_y_r, d_r);

  // bounds update
  coord_t cx, cy;
  coord_t low_x_n, high_x_n, low_y_n, high_y_n;
  logic   hit_n;

  assign cx       = finish(q_x_r, neg_x_r);
  assign cy       = finish(q_y_r, neg_y_r);
  assign low_x_n  = (crossing && (cx < run_low_x_r))  ? cx : run_low_x_r;
  assign high_x_n = (crossing && (cx > run_high_x_r)) ? cx : run_high_x_r;
  assign low_y_n  = (crossing && (cy < run_low_y_r))  ? cy : run_low_y_r;
  assign high_y_n = (crossing && (cy > run_high_y_r)) ? cy : run_high_y_r;
  assign hit_n    = hit_r | crossing;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1_r   <= in_start_x;
      y1_r   <= in_start_y;
      z1_r   <= in_start_z;
      x2_r   <= in_end_x;
      y2_r   <= in_end_y;
      z2_r   <= in_end_z;
      last_r <= in_last_edge;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_step)
        MUL_XA:  num_x_r <= prod_ext;
        MUL_XB:  num_x_r <= num_x_r - prod_ext;
        MUL_YA:  num_y_r <= prod_ext;
        MUL_YB:  num_y_r <= num_y_r - prod_ext;
        default: num_x_r <= prod_ext;
      endcase
    end
    if (cmd.prep) begin
      d_r     <= den_mag;
      rem_x_r <= nmag_x[NUM_W-1:COORD_W];
      q_x_r   <= nmag_x[COORD_W-1:0];
      rem_y_r <= nmag_y[NUM_W-1:COORD_W];
      q_y_r   <= nmag_y[COORD_W-1:0];
      neg_x_r <= num_x_r[NUM_W-1] ^ den[DEN_W-1];
      neg_y_r <= num_y_r[NUM_W-1] ^ den[DEN_W-1];
    end
    if (cmd.div_en) begin
      {rem_x_r, q_x_r} <= step_x;
      {rem_y_r, q_y_r} <= step_y;
    end
    if (cmd.upd && last_r) begin
      out_low_x_r  <= hit_n ? low_x_n  : '0;
      out_high_x_r <= hit_n ? high_x_n : '0;
      out_low_y_r  <= hit_n ? low_y_n  : '0;
      out_high_y_r <= hit_n ? high_y_n : '0;
      out_found_r  <= hit_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_low_x_r  <= COORD_MAX;
      run_high_x_r <= COORD_MIN;
      run_low_y_r  <= COORD_MAX;
      run_high_y_r <= COORD_MIN;
      hit_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.upd) begin
        if (last_r) begin
          run_low_x_r  <= COORD_MAX;
          run_high_x_r <= COORD_MIN;
          run_low_y_r  <= COORD_MAX;
          run_high_y_r <= COORD_MIN;
          hit_r        <= 1'b0;
        end else begin
          run_low_x_r  <= low_x_n;
          run_high_x_r <= high_x_n;
          run_low_y_r  <= low_y_n;
          run_high_y_r <= high_y_n;
          hit_r        <= hit_n;
        end
      end
      if (cmd.upd && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_low_x  = out_low_x_r;
  assign out_high_x = out_high_x_r;
  assign out_low_y  = out_low_y_r;
  assign out_high_y = out_high_y_r;
  assign out_found  = out_found_r;

endmodule

FILE: hw/rtl/plane_slice_edge_bounds_core.sv
// Sequence per edge word that crosses z=0: idle, 4 multiply passes, a setup,
// 32 radix-2 divider steps and an update; any other edge goes from the
// multiply state straight to the update. A final edge also waits in the
// update state while the previous result word has not been taken.
// Reset: synchronous active-low rst_n clears the sequencer, the running
// bounds (low to most positive, high to most negative) and the result valid.
`timescale 1ns / 1ps

module plane_slice_edge_bounds_core import pseb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pseb_in_if.sink     in_edge,
  pseb_out_if.source  out_rect
);

  // Controller and datapath talk only through cmd / sts.
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // The sequencer takes an edge word only in idle; the datapath's result
  // register decouples the output side, so a new box may start while the
  // last rectangle is still waiting to be taken. Only a final edge that
  // finds the result register full waits in the update state.
  pseb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_edge.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  assign in_edge.ready = in_ready;

  // Per crossing edge: numerators x1*z2 - z1*x2 and y1*z2 - z1*y2 are built
  // on one 32x32 multiplier over four passes; the common denominator
  // z2 - z1 feeds two restoring dividers that run side by side. The
  // crossing point lies between the endpoints, so 32 quotient bits cover it.
  pseb_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_start_x   (in_edge.start_x),
    .in_start_y   (in_edge.start_y),
    .in_start_z   (in_edge.start_z),
    .in_end_x     (in_edge.end_x),
    .in_end_y     (in_edge.end_y),
    .in_end_z     (in_edge.end_z),
    .in_last_edge (in_edge.last_edge),
    .out_valid    (out_rect.valid),
    .out_ready    (out_rect.ready),
    .out_low_x    (out_rect.low_x),
    .out_high_x   (out_rect.high_x),
    .out_low_y    (out_rect.low_y),
    .out_high_y   (out_rect.high_y),
    .out_found    (out_rect.found)
  );

endmodule

FILE: hw/rtl/pseb_checker.sv
// Port-level checks for the plane slice edge bounds block, bound to the
// top level. Depends on pseb_pkg and the top level's channel ports.
`timescale 1ns / 1ps

module pseb_checker import pseb_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   in_valid,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input coord_t out_low_x,
  input coord_t out_high_x,
  input coord_t out_low_y,
  input coord_t out_high_y,
  input logic   out_found
);

  // a held result word stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a held result word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_low_x) && $stable(out_high_x)
      && $stable(out_low_y) && $stable(out_high_y) && $stable(out_found))
    else $error("result word changed while stalled");

  // no crossing: bounds read as zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_low_x == '0 && out_high_x == '0
      && out_low_y == '0 && out_high_y == '0)
    else $error("empty rectangle with nonzero bounds");

  // a found rectangle is ordered
  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_low_x <= out_high_x && out_low_y <= out_high_y)
    else $error("rectangle bounds out of order");

  // one edge at a time: no accept in the cycle after an accept
  a_one_edge: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("edge word taken while busy");

endmodule

bind plane_slice_edge_bounds_core pseb_checker u_pseb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_edge.valid),
  .in_ready   (in_edge.ready),
  .out_valid  (out_rect.valid),
  .out_ready  (out_rect.ready),
  .out_low_x  (out_rect.low_x),
  .out_high_x (out_rect.high_x),
  .out_low_y  (out_rect.low_y),
  .out_high_y (out_rect.high_y),
  .out_found  (out_rect.found)
);

FILE: tb/testbench.sv
// Self-checking bench for plane_slice_edge_bounds_core: edge words go in over
// pseb_in_if, rectangle words are checked against a built-in bounds predictor.
// Depends on pseb_pkg, pseb_if and the core.
`timescale 1ns / 1ps

module testbench;
  import pseb_pkg::*;

  // one edge word as it travels on the input channel
  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
    logic   last_edge;
  } edge_word_t;

  // one rectangle word as it comes back on the result channel
  typedef struct packed {
    coord_t low_x;
    coord_t high_x;
    coord_t low_y;
    coord_t high_y;
    logic   found;
  } rect_t;

  // directed row: when typed is set, want is the rectangle read straight off
  // the spec; otherwise the predictor supplies it
  typedef struct packed {
    logic       typed;
    rect_t      want;
    edge_word_t word;
  } stim_row_t;

  localparam coord_t ONE       = 32'sh0001_0000;  // 1.0 in Q16.16
  localparam rect_t  NO_HIT    = '0;
  localparam int     LINGER    = 48;              // stray-word watch after the last drain
  localparam int     MAX_NOTES = 10;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  pseb_in_if  in_edge ();
  pseb_out_if out_rect ();

  plane_slice_edge_bounds_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_edge  (in_edge),
    .out_rect (out_rect)
  );

  // idle rates in percent, changed per phase
  int send_idle;
  int recv_idle;

  int fail_cnt;
  int edge_cnt;
  int cross_cnt;
  int rect_cnt;
  int empty_cnt;

  // rectangles still owed by the core, oldest first
  rect_t rect_q[$];
  rect_t head;

  // predictor copy of the running box bounds
  coord_t box_low_x;
  coord_t box_high_x;
  coord_t box_low_y;
  coord_t box_high_y;
  logic   box_hit;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  task automatic clear_box();
    box_low_x  = COORD_MAX;
    box_low_y  = COORD_MAX;
    box_high_x = COORD_MIN;
    box_high_y = COORD_MIN;
    box_hit    = 1'b0;
  endtask

  // Crossing coordinate (p1*q2 - q1*p2) / (q2 - q1). 96-bit signed context
  // keeps the numerator exact; SV division truncates toward zero, as the
  // core does. Since the point is a convex mix of p1 and p2, clipping should
  // never bite, but the core saturates so the predictor does too.
  function automatic coord_t cross_coord(coord_t p1, coord_t q1, coord_t p2, coord_t q2);
    logic signed [95:0] num;
    logic signed [95:0] den;
    logic signed [95:0] quo;
    num = p1 * q2 - q1 * p2;
    den = q2 - q1;
    quo = num / den;
    if (quo > COORD_MAX) return COORD_MAX;
    if (quo < COORD_MIN) return COORD_MIN;
    return quo[COORD_W-1:0];
  endfunction

  // Fold one accepted edge into the running box; on the last edge queue the
  // rectangle the core owes us and start a fresh box.
  task automatic fold_edge(input stim_row_t row);
    coord_t z1;
    coord_t z2;
    coord_t cx;
    coord_t cy;
    rect_t  r;
    z1 = row.word.start_z;
    z2 = row.word.end_z;
    // opposite sides or touching, but a flat edge never counts
    if (((z1 <= 0 && z2 >= 0) || (z1 >= 0 && z2 <= 0)) && z1 != z2) begin
      cx = cross_coord(row.word.start_x, z1, row.word.end_x, z2);
      cy = cross_coord(row.word.start_y, z1, row.word.end_y, z2);
      if (cx < box_low_x)  box_low_x  = cx;
      if (cx > box_high_x) box_high_x = cx;
      if (cy < box_low_y)  box_low_y  = cy;
      if (cy > box_high_y) box_high_y = cy;
      box_hit = 1'b1;
      cross_cnt++;
    end
    if (row.word.last_edge) begin
      r = box_hit ? rect_t'{box_low_x, box_high_x, box_low_y, box_high_y, 1'b1} : NO_HIT;
      rect_q.push_back(row.typed ? row.want : r);
      clear_box();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic stim_row_t mk(input coord_t sx, input coord_t sy, input coord_t sz,
                                   input coord_t ex, input coord_t ey, input coord_t ez,
                                   input logic last, input logic typed = 1'b0,
                                   input rect_t want = NO_HIT);
    stim_row_t row;
    row.word  = '{sx, sy, sz, ex, ey, ez, last};
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  // coordinate mix: range ends, zero, small values near the origin, full random
  function automatic coord_t rnd_coord();
    case ($urandom_range(9))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return '0;
      3, 4, 5: return coord_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      default: return coord_t'($urandom());
    endcase
  endfunction

  // Random edge. With may_cross set, mostly plane crossers (with either end on
  // the plane now and then); the rest are flat edges or edges wholly above or below.
  function automatic edge_word_t rand_word(input logic may_cross, input logic last);
    edge_word_t w;
    coord_t     a;
    coord_t     b;
    int         kind;
    w.start_x   = rnd_coord();
    w.start_y   = rnd_coord();
    w.end_x     = rnd_coord();
    w.end_y     = rnd_coord();
    w.last_edge = last;
    kind = $urandom_range(9);
    a = rnd_coord();
    b = rnd_coord();
    if (a > 0) a = -a;  // a <= 0 (most negative maps to itself)
    if (b < 0) b = ~b;  // b >= 0
    if (may_cross && kind < 7) begin
      if (a == 0 && b == 0) b = 1;
    end else if (kind == 7) begin
      a = rnd_coord();  // flat, zero height included
      b = a;
    end else if ($urandom_range(1)) begin
      if (a == 0) a = -1;  // both strictly below
      b = ~b;
    end else begin
      a = ~a;              // both strictly above
      if (a <= 0) a = 1;
      if (b == 0) b = 1;
    end
    if ($urandom_range(1)) begin
      w.start_z = a;
      w.end_z   = b;
    end else begin
      w.start_z = b;
      w.end_z   = a;
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: change at negedge, handshake seen at posedge
  // ---------------------------------------------------------------------------

  task automatic send_word(input stim_row_t row);
    int gap;
    gap = ($urandom_range(99) < send_idle) ? $urandom_range(1, 6) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_edge.valid = 1'b0;
    end
    @(negedge clk);
    in_edge.valid     = 1'b1;
    in_edge.start_x   = row.word.start_x;
    in_edge.start_y   = row.word.start_y;
    in_edge.start_z   = row.word.start_z;
    in_edge.end_x     = row.word.end_x;
    in_edge.end_y     = row.word.end_y;
    in_edge.end_z     = row.word.end_z;
    in_edge.last_edge = row.word.last_edge;
    do @(posedge clk); while (!in_edge.ready);
    fold_edge(row);
    edge_cnt++;
  endtask

  // hold off the sender until every owed rectangle is back
  task automatic drain();
    @(negedge clk);
    in_edge.valid = 1'b0;
    while (rect_q.size() != 0) @(posedge clk);
  endtask

  // Random boxes of 1..12 edges, the last one flagged. About one box in
  // eight has no crossers, so found=0 shows up in the random part too.
  task automatic run_boxes(input int n_words);
    int        sent;
    int        box_len;
    logic      may_cross;
    stim_row_t row;
    sent = 0;
    while (sent < n_words) begin
      box_len   = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 12);
      may_cross = ($urandom_range(7) != 0);
      for (int k = 0; k < box_len; k++) begin
        row      = '0;
        row.word = rand_word(may_cross, k == box_len - 1);
        send_word(row);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    out_rect.ready = ($urandom_range(99) >= recv_idle);
  end

  task automatic check_field(input string name, input coord_t want, input coord_t got);
    if (want !== got) begin
      fail_cnt++;
      if (fail_cnt <= MAX_NOTES)
        $display("rect #%0d %s: expected %0d (0x%08h), got %0d (0x%08h)",
                 rect_cnt, name, want, want, got, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_rect.valid && out_rect.ready) begin
      if (rect_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_NOTES)
          $display("rectangle word with none owed: low_x %0d high_x %0d found %0b",
                   out_rect.low_x, out_rect.high_x, out_rect.found);
      end else begin
        head = rect_q.pop_front();
        rect_cnt++;
        if (!head.found) empty_cnt++;
        check_field("low_x",  head.low_x,  out_rect.low_x);
        check_field("high_x", head.high_x, out_rect.high_x);
        check_field("low_y",  head.low_y,  out_rect.low_y);
        check_field("high_y", head.high_y, out_rect.high_y);
        check_field("found",  coord_t'(head.found), coord_t'(out_rect.found));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    stim_row_t dir_tab[$];
    in_edge.valid     = 1'b0;
    in_edge.start_x   = '0;
    in_edge.start_y   = '0;
    in_edge.start_z   = '0;
    in_edge.end_x     = '0;
    in_edge.end_y     = '0;
    in_edge.end_z     = '0;
    in_edge.last_edge = 1'b0;
    out_rect.ready    = 1'b0;
    fail_cnt  = 0;
    edge_cnt  = 0;
    cross_cnt = 0;
    rect_cnt  = 0;
    empty_cnt = 0;
    clear_box();

    // phase 1 idling: eager sender, busy receiver
    send_idle = 23;
    recv_idle = 76;

    // straight after reset, both ends above the plane: empty rectangle
    dir_tab.push_back(mk(ONE, ONE, ONE, -ONE, -ONE, 2 * ONE, 1'b1, 1'b1, NO_HIT));
    // flat edge lying in the plane never counts
    dir_tab.push_back(mk(5 * ONE, -ONE, 0, -ONE, 3, 0, 1'b1, 1'b1, NO_HIT));
    // vertical edge through the plane at (1.0, -2.0)
    dir_tab.push_back(mk(ONE, -2 * ONE, -ONE, ONE, -2 * ONE, ONE, 1'b1, 1'b1,
                         rect_t'{ONE, ONE, -2 * ONE, -2 * ONE, 1'b1}));
    // range ends everywhere; the crossing lands exactly on them
    dir_tab.push_back(mk(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                         1'b1, 1'b1,
                         rect_t'{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1}));
    // start point on the plane: crossing is the start point
    dir_tab.push_back(mk(32'sh0012_3456, -32'sh0000_0789, 0, COORD_MAX, COORD_MIN, 5 * ONE,
                         1'b1, 1'b1,
                         rect_t'{32'sh0012_3456, 32'sh0012_3456,
                                 -32'sh0000_0789, -32'sh0000_0789, 1'b1}));
    // end point on the plane: crossing is the end point
    dir_tab.push_back(mk(COORD_MAX, COORD_MIN, -3 * ONE, -7, 9, 0, 1'b1, 1'b1,
                         rect_t'{-7, -7, 9, 9, 1'b1}));
    // all-ones words
    dir_tab.push_back(mk(-1, -1, -1, -1, -1, 1, 1'b1, 1'b1, rect_t'{-1, -1, -1, -1, 1'b1}));
    // thirds: truncation toward zero on both signs
    dir_tab.push_back(mk(0, 0, -1, 1, -1, 2, 1'b1));
    // a four-crosser box closed by a flat edge above the plane
    dir_tab.push_back(mk(3 * ONE, -4 * ONE, -2 * ONE, -ONE, 6 * ONE, ONE, 1'b0));
    dir_tab.push_back(mk(COORD_MIN, COORD_MAX, ONE, COORD_MAX, COORD_MIN, -ONE, 1'b0));
    dir_tab.push_back(mk(32'sh1234_5678, -32'sh0765_4321, COORD_MIN,
                         -32'sh0fed_cba9, 32'sh0000_1111, 7, 1'b0));
    dir_tab.push_back(mk(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
                         1'b0));
    dir_tab.push_back(mk(ONE, 2 * ONE, 3 * ONE, -ONE, -2 * ONE, 3 * ONE, 1'b1));
    // the box above must not leak into this one: flat below, then wholly below
    dir_tab.push_back(mk(ONE, ONE, -ONE, 2 * ONE, 2 * ONE, -ONE, 1'b0));
    dir_tab.push_back(mk(0, 0, -5, 0, 0, -9, 1'b1, 1'b1, NO_HIT));
    // deepest start, end on the plane
    dir_tab.push_back(mk(7, -7, COORD_MIN, COORD_MAX, COORD_MIN, 0, 1'b1));
    // flat at zero height, then a crosser leaving the plane downward
    dir_tab.push_back(mk(0, 0, 0, 0, 0, 0, 1'b0));
    dir_tab.push_back(mk(COORD_MAX, COORD_MAX, 0, COORD_MIN, COORD_MIN, -ONE, 1'b1));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) send_word(dir_tab[i]);
    run_boxes(500);
    drain();

    // phase 2: busy sender, eager receiver
    send_idle = 76;
    recv_idle = 23;
    run_boxes(520);
    drain();

    // phase 3: full rate both ways
    send_idle = 0;
    recv_idle = 0;
    run_boxes(520);
    drain();

    // watch for stray rectangle words after the last one owed
    repeat (LINGER) @(posedge clk);

    $display("%0d edge words driven, %0d of them crossing z=0", edge_cnt, cross_cnt);
    $display("%0d rectangle words compared (%0d empty), %0d field mismatches",
             rect_cnt, empty_cnt, fail_cnt);
    if (fail_cnt == 0 && rect_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // watchdog: set at several times the slowest legal run
  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/pseb_pkg.sv
hw/rtl/pseb_if.sv
hw/rtl/pseb_ctrl.sv
hw/rtl/pseb_datapath.sv
hw/rtl/plane_slice_edge_bounds_core.sv
hw/rtl/pseb_checker.sv
tb/testbench.sv
